FILE: src/udp_ipv4_frame_builder_assert.svh
// Assertion macros shared by the frame builder checker.
// Depends on nothing; a file that uses them provides aclk and aresetn.
`ifndef UDP_IPV4_FRAME_BUILDER_ASSERT_SVH
`define UDP_IPV4_FRAME_BUILDER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define UFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/udpfb_pkg.sv
// Shared types and constants of the UDP/IPv4 frame builder.
// Depends on nothing; imported by the checksum unit, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package udpfb_pkg;

    localparam int HDR_LEN = 42;
    localparam int IP_UDP_HDR_LEN = 28;
    localparam int UDP_HDR_LEN = 8;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [2:0] CFG_SRC_MAC = 3'd0;
    localparam logic [2:0] CFG_DST_MAC = 3'd1;
    localparam logic [2:0] CFG_SRC_IP = 3'd2;
    localparam logic [2:0] CFG_DST_IP = 3'd3;
    localparam logic [2:0] CFG_SRC_PORT = 3'd4;
    localparam logic [2:0] CFG_DST_PORT = 3'd5;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0] IP_VER_IHL = 8'h45;
    localparam logic [7:0] IP_TTL = 8'd64;
    localparam logic [7:0] IP_PROTO_UDP = 8'd17;
    localparam logic [15:0] IP_FIXED_SUM = 16'h8511;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [31:0] data_sum;
    } udpfb_csum_in_t;

    typedef struct packed {
        logic [15:0] ip_csum;
        logic [15:0] udp_csum;
    } udpfb_csum_out_t;

endpackage

`default_nettype wire

FILE: src/udpfb_csum.sv
// Two-stage pipelined IPv4 header and UDP checksum unit with a final fold.
// Depends on udpfb_pkg; results pass through both registered stages, and the fold is combinational.
`timescale 1ns / 1ps
`default_nettype none

module udpfb_csum
    import udpfb_pkg::*;
(
    input  wire logic            aclk,
    input  wire udpfb_csum_in_t  csum_in,
    output udpfb_csum_out_t      csum_out
);

    logic [17:0] ip_pair_reg;
    logic [16:0] port_pair_reg;
    logic [15:0] ip_len_reg;
    logic [15:0] udp_len_reg;
    logic [31:0] data_sum_reg;
    logic [31:0] ip_sum_reg;
    logic [31:0] udp_sum_reg;

    function automatic logic [15:0] fold_invert(input logic [31:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
        s2 = s1 + {16'd0, s1[16]};
        return ~s2[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        ip_pair_reg <= {2'b00, csum_in.src_ip[31:16]} + {2'b00, csum_in.src_ip[15:0]}
                     + {2'b00, csum_in.dst_ip[31:16]} + {2'b00, csum_in.dst_ip[15:0]};
        port_pair_reg <= {1'b0, csum_in.src_port} + {1'b0, csum_in.dst_port};
        ip_len_reg <= csum_in.ip_len;
        udp_len_reg <= csum_in.udp_len;
        data_sum_reg <= csum_in.data_sum;

        ip_sum_reg <= {14'd0, ip_pair_reg} + {16'd0, IP_FIXED_SUM} + {16'd0, ip_len_reg};
        udp_sum_reg <= {14'd0, ip_pair_reg} + {24'd0, IP_PROTO_UDP}
                     + {15'd0, udp_len_reg, 1'b0} + {15'd0, port_pair_reg} + data_sum_reg;
    end

    assign csum_out.ip_csum = fold_invert(ip_sum_reg);
    assign csum_out.udp_csum = fold_invert(udp_sum_reg);

endmodule

`default_nettype wire

FILE: src/udp_ipv4_frame_builder.sv
// Top level of the UDP/IPv4/Ethernet frame builder with its payload memory.
// Depends on udpfb_pkg and udpfb_csum.
//
// Words enter on the s_ stream. s_tuser selects the operation: 0 appends the
// payload byte in s_tdata, with s_tlast on the final byte of a datagram; 1 pulls
// the next byte of the built frame. Results leave on the m_ stream with the frame
// byte in m_tdata, the final frame byte flagged by m_tlast and the status in
// m_tuser. The cfg_ port writes the addresses and ports, one register per cycle.
// An append that is not last gives no result, so payload streams in at one byte
// per clock while s_tready holds. A closing append gives its status in the cycle
// after acceptance. A pull of a ready frame steps through ST_SUM, ST_CSUM and
// ST_FOLD: the payload memory read is registered, the checksum pipeline settles,
// then the byte is formed and registered. A pull with no frame ready answers in
// the cycle after acceptance. New words are taken only while no result is pending,
// so a stalled receiver holds the result in the output register and stalls the
// input side. Reset empties the datagram state and clears the output valid flag
// and the configuration registers; the payload memory needs no clearing since
// only bytes of the current datagram are read.
`timescale 1ns / 1ps
`default_nettype none

module udp_ipv4_frame_builder
    import udpfb_pkg::*;
#(
    parameter int MAX_FRAME = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // data_byte
    input  wire logic        s_tuser,      // opcode
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,      // frame_byte
    output logic [1:0]       m_tuser,      // status
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [47:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int PAYLOAD_MAX = MAX_FRAME - HDR_LEN;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM = 2'd1;
    localparam logic [1:0] ST_CSUM = 2'd2;
    localparam logic [1:0] ST_FOLD = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [47:0]      src_mac_reg, dst_mac_reg;
    logic [31:0]      src_ip_reg, dst_ip_reg;
    logic [15:0]      src_port_reg, dst_port_reg;
    logic [CNT_W-1:0] payload_count_reg, payload_count_next;
    logic [31:0]      data_sum_reg, data_sum_next;
    logic [CNT_W-1:0] read_pos_reg, read_pos_next;
    logic             frame_ready_reg, frame_ready_next;
    logic             too_long_reg, too_long_next;
    logic [CNT_W-1:0] pos_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;

    logic [7:0]       store_mem [MAX_FRAME];
    logic [7:0]       rd_data_reg;

    logic             s_acc;
    logic             do_append, do_pull;
    logic [CNT_W-1:0] cnt_eff;
    logic [31:0]      sum_eff;
    logic             too_long_eff;
    logic             room;
    logic [31:0]      byte_term;
    logic [CNT_W-1:0] rd_index;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic             rd_en;
    logic [CNT_W:0]   pos_plus1, total_len;
    logic             frame_end;
    logic [5:0]       hpos;
    logic [5:0]       mac_sh;
    logic [1:0]       ip_sh;
    logic [7:0]       hdr_byte;
    logic [15:0]      ip_len, udp_len;
    udpfb_csum_in_t   csum_in;
    udpfb_csum_out_t  csum_out;

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_acc = s_tvalid && s_tready;
    assign do_append = s_acc && (s_tuser == OP_APPEND);
    assign do_pull = s_acc && (s_tuser == OP_PULL);

    assign cnt_eff = frame_ready_reg ? '0 : payload_count_reg;
    assign sum_eff = frame_ready_reg ? 32'd0 : data_sum_reg;
    assign too_long_eff = frame_ready_reg ? 1'b0 : too_long_reg;
    assign room = cnt_eff < CNT_W'(PAYLOAD_MAX);
    assign byte_term = cnt_eff[0] ? {24'd0, s_tdata} : {16'd0, s_tdata, 8'd0};

    assign wr_addr = cnt_eff[ADDR_W-1:0];
    assign rd_index = read_pos_reg - CNT_W'(HDR_LEN);
    assign rd_addr = rd_index[ADDR_W-1:0];
    assign rd_en = do_pull && frame_ready_reg && (read_pos_reg >= CNT_W'(HDR_LEN));

    always_ff @(posedge aclk) begin
        if (do_append && room) begin
            store_mem[wr_addr] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign ip_len = 16'(payload_count_reg) + 16'(IP_UDP_HDR_LEN);
    assign udp_len = 16'(payload_count_reg) + 16'(UDP_HDR_LEN);

    assign csum_in.src_ip = src_ip_reg;
    assign csum_in.dst_ip = dst_ip_reg;
    assign csum_in.src_port = src_port_reg;
    assign csum_in.dst_port = dst_port_reg;
    assign csum_in.ip_len = ip_len;
    assign csum_in.udp_len = udp_len;
    assign csum_in.data_sum = data_sum_reg;

    udpfb_csum u_csum (
        .aclk     (aclk),
        .csum_in  (csum_in),
        .csum_out (csum_out)
    );

    assign hpos = pos_reg[5:0];
    assign mac_sh = (hpos < 6'd6) ? (6'd5 - hpos) : (6'd11 - hpos);
    assign ip_sh = (hpos < 6'd30) ? 2'(6'd29 - hpos) : 2'(6'd33 - hpos);

    always_comb begin
        hdr_byte = 8'h00;
        if (hpos < 6'd6) begin
            hdr_byte = 8'(dst_mac_reg >> {mac_sh, 3'b000});
        end else if (hpos < 6'd12) begin
            hdr_byte = 8'(src_mac_reg >> {mac_sh, 3'b000});
        end else if (hpos >= 6'd26 && hpos < 6'd30) begin
            hdr_byte = 8'(src_ip_reg >> {ip_sh, 3'b000});
        end else if (hpos >= 6'd30 && hpos < 6'd34) begin
            hdr_byte = 8'(dst_ip_reg >> {ip_sh, 3'b000});
        end else begin
            case (hpos)
                6'd12: hdr_byte = ETH_TYPE_IPV4[15:8];
                6'd13: hdr_byte = ETH_TYPE_IPV4[7:0];
                6'd14: hdr_byte = IP_VER_IHL;
                6'd16: hdr_byte = ip_len[15:8];
                6'd17: hdr_byte = ip_len[7:0];
                6'd22: hdr_byte = IP_TTL;
                6'd23: hdr_byte = IP_PROTO_UDP;
                6'd24: hdr_byte = csum_out.ip_csum[15:8];
                6'd25: hdr_byte = csum_out.ip_csum[7:0];
                6'd34: hdr_byte = src_port_reg[15:8];
                6'd35: hdr_byte = src_port_reg[7:0];
                6'd36: hdr_byte = dst_port_reg[15:8];
                6'd37: hdr_byte = dst_port_reg[7:0];
                6'd38: hdr_byte = udp_len[15:8];
                6'd39: hdr_byte = udp_len[7:0];
                6'd40: hdr_byte = csum_out.udp_csum[15:8];
                6'd41: hdr_byte = csum_out.udp_csum[7:0];
                default: hdr_byte = 8'h00;
            endcase
        end
    end

    assign pos_plus1 = {1'b0, pos_reg} + (CNT_W+1)'(1);
    assign total_len = {1'b0, payload_count_reg} + (CNT_W+1)'(HDR_LEN);
    assign frame_end = pos_plus1 >= total_len;

    always_comb begin
        state_next = state_reg;
        payload_count_next = payload_count_reg;
        data_sum_next = data_sum_reg;
        read_pos_next = read_pos_reg;
        frame_ready_next = frame_ready_reg;
        too_long_next = too_long_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (do_append) begin
                    payload_count_next = cnt_eff;
                    data_sum_next = sum_eff;
                    too_long_next = too_long_eff;
                    frame_ready_next = 1'b0;
                    if (frame_ready_reg) begin
                        read_pos_next = '0;
                    end
                    if (room) begin
                        payload_count_next = cnt_eff + CNT_W'(1);
                        data_sum_next = sum_eff + byte_term;
                    end else begin
                        too_long_next = 1'b1;
                    end
                    if (s_tlast) begin
                        m_valid_next = 1'b1;
                        m_data_next = 8'h00;
                        m_last_next = 1'b0;
                        if (too_long_eff || !room) begin
                            m_status_next = STATUS_DROPPED;
                            payload_count_next = '0;
                            data_sum_next = 32'd0;
                            read_pos_next = '0;
                            too_long_next = 1'b0;
                        end else begin
                            m_status_next = STATUS_OK;
                            frame_ready_next = 1'b1;
                            read_pos_next = '0;
                        end
                    end
                end else if (do_pull) begin
                    if (frame_ready_reg) begin
                        state_next = ST_SUM;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next = 8'h00;
                        m_last_next = 1'b0;
                        m_status_next = STATUS_EMPTY;
                    end
                end
            end
            ST_SUM: begin
                state_next = ST_CSUM;
            end
            ST_CSUM: begin
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                state_next = ST_IDLE;
                m_valid_next = 1'b1;
                m_status_next = STATUS_OK;
                m_data_next = (pos_reg < CNT_W'(HDR_LEN)) ? hdr_byte : rd_data_reg;
                m_last_next = frame_end;
                if (frame_end) begin
                    payload_count_next = '0;
                    data_sum_next = 32'd0;
                    read_pos_next = '0;
                    frame_ready_next = 1'b0;
                    too_long_next = 1'b0;
                end else begin
                    read_pos_next = pos_plus1[CNT_W-1:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            payload_count_reg <= '0;
            data_sum_reg <= 32'd0;
            read_pos_reg <= '0;
            frame_ready_reg <= 1'b0;
            too_long_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            src_mac_reg <= 48'd0;
            dst_mac_reg <= 48'd0;
            src_ip_reg <= 32'd0;
            dst_ip_reg <= 32'd0;
            src_port_reg <= 16'd0;
            dst_port_reg <= 16'd0;
        end else begin
            state_reg <= state_next;
            payload_count_reg <= payload_count_next;
            data_sum_reg <= data_sum_next;
            read_pos_reg <= read_pos_next;
            frame_ready_reg <= frame_ready_next;
            too_long_reg <= too_long_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SRC_MAC: src_mac_reg <= cfg_wr_data;
                    CFG_DST_MAC: dst_mac_reg <= cfg_wr_data;
                    CFG_SRC_IP: src_ip_reg <= cfg_wr_data[31:0];
                    CFG_DST_IP: dst_ip_reg <= cfg_wr_data[31:0];
                    CFG_SRC_PORT: src_port_reg <= cfg_wr_data[15:0];
                    CFG_DST_PORT: dst_port_reg <= cfg_wr_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pull) begin
            pos_reg <= read_pos_reg;
        end
        m_data_reg <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_status_reg;
    assign m_tlast = m_last_reg;

endmodule

`default_nettype wire

FILE: src/udp_ipv4_frame_builder_checker.sv
// Port-level checker for the frame builder and the bind that attaches it.
// Depends on udpfb_pkg and udp_ipv4_frame_builder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "udp_ipv4_frame_builder_assert.svh"

module udp_ipv4_frame_builder_checker
    import udpfb_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic s_word;
    logic m_stall;

    assign s_word = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    `UFB_ASSERT_NEXT(a_out_hold, m_stall,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result word changed")

    `UFB_ASSERT_SAME(a_status_payload, m_tvalid && m_tuser != STATUS_OK,
        m_tdata == 8'h00 && !m_tlast, "non-ok status carries frame data")

    `UFB_ASSERT_SAME(a_last_ok, m_tvalid && m_tlast, m_tuser == STATUS_OK,
        "frame end flagged with a non-ok status")

    `UFB_ASSERT_NEXT(a_append_silent, s_word && s_tuser == OP_APPEND && !s_tlast,
        !m_tvalid, "inner payload byte produced a result")

endmodule

bind udp_ipv4_frame_builder udp_ipv4_frame_builder_checker u_checker (.*);

`default_nettype wire
